/* hdl/nrmc_pkg.sv */
// Shared constants, types and helpers of the RMC sentence parser.
package nrmc_pkg;

  localparam int unsigned MaxSentenceLen = 128;
  localparam int unsigned PosFracDigits  = 4;
  localparam int unsigned RateFracDigits = 2;

  localparam int unsigned AccW = 28;
  localparam int unsigned PadW = 20;   // holds 10^6, the largest pad factor

  function automatic longint unsigned pow10(int unsigned n);
    longint unsigned r;
    r = 64'd1;
    for (int unsigned i = 0; i < n; i++) begin
      r = r * 64'd10;
    end
    return r;
  endfunction

  function automatic logic [AccW-1:0] cap_max(longint unsigned v, longint unsigned mask);
    return AccW'((v > mask) ? mask : v);
  endfunction

  // Field maxima
  localparam logic [AccW-1:0] MaxTime  = AccW'(235959);
  localparam logic [AccW-1:0] MaxLat   =
    cap_max(64'd9000 * pow10(PosFracDigits), 64'h7FF_FFFF);
  localparam logic [AccW-1:0] MaxLon   =
    cap_max(64'd18000 * pow10(PosFracDigits), 64'hFFF_FFFF);
  localparam logic [AccW-1:0] MaxSpeed =
    cap_max(64'd100000 * pow10(RateFracDigits) - 64'd1, 64'hFF_FFFF);
  localparam logic [AccW-1:0] MaxHead  =
    cap_max(64'd360 * pow10(RateFracDigits), 64'hFFFF);
  localparam logic [AccW-1:0] MaxDate  = AccW'(311299);

  // Pad factors 10^k for k = 0..6, entry 7 repeats 10^6 (k never exceeds 4 in use)
  localparam logic [PadW-1:0] PadTab [8] = '{
    20'd1, 20'd10, 20'd100, 20'd1000, 20'd10000, 20'd100000, 20'd1000000, 20'd1000000
  };

  // Field numbers, counted from the header field
  localparam logic [3:0] FldTime  = 4'd1;
  localparam logic [3:0] FldValid = 4'd2;
  localparam logic [3:0] FldLat   = 4'd3;
  localparam logic [3:0] FldNs    = 4'd4;
  localparam logic [3:0] FldLon   = 4'd5;
  localparam logic [3:0] FldEw    = 4'd6;
  localparam logic [3:0] FldSpeed = 4'd7;
  localparam logic [3:0] FldHead  = 4'd8;
  localparam logic [3:0] FldDate  = 4'd9;
  localparam logic [3:0] FldLast  = 4'd15;

  localparam logic [2:0] FracClosed = 3'd7;

  // Characters
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharComma  = 8'h2C;
  localparam logic [7:0] CharDot    = 8'h2E;
  localparam logic [7:0] Char0      = 8'h30;
  localparam logic [7:0] Char9      = 8'h39;
  localparam logic [7:0] CharA      = 8'h41;
  localparam logic [7:0] CharN      = 8'h4E;
  localparam logic [7:0] CharS      = 8'h53;
  localparam logic [7:0] CharE      = 8'h45;
  localparam logic [7:0] CharW      = 8'h57;

  localparam logic [7:0] HdrText [5] = '{8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};  // GPRMC

  typedef struct packed {
    logic            is_num;
    logic [2:0]      frac_digits;
    logic [AccW-1:0] max_val;
  } nrmc_fld_t;

endpackage

/* hdl/nrmc_num_unit.sv */
// Saturating decimal arithmetic for the numeric fields: digit step and fraction pad.
module nrmc_num_unit import nrmc_pkg::*; (
  input  logic [3:0]      field_idx_i,
  input  logic [AccW-1:0] acc_i,
  input  logic [2:0]      frac_cnt_i,
  input  logic [3:0]      digit_i,
  output nrmc_fld_t       fld_o,
  output logic [AccW-1:0] mac_o,
  output logic [AccW-1:0] close_o
);

  logic [31:0]           mac_sum;
  logic [2:0]            pad_idx;
  logic [AccW+PadW-1:0]  pad_prod;

  always_comb begin
    fld_o = '{is_num: 1'b0, frac_digits: 3'd0, max_val: '0};
    case (field_idx_i)
      FldTime:  fld_o = '{1'b1, 3'd0, MaxTime};
      FldLat:   fld_o = '{1'b1, 3'(PosFracDigits), MaxLat};
      FldLon:   fld_o = '{1'b1, 3'(PosFracDigits), MaxLon};
      FldSpeed: fld_o = '{1'b1, 3'(RateFracDigits), MaxSpeed};
      FldHead:  fld_o = '{1'b1, 3'(RateFracDigits), MaxHead};
      FldDate:  fld_o = '{1'b1, 3'd0, MaxDate};
      default:  fld_o = '{1'b0, 3'd0, '0};
    endcase
  end

  // acc * 10 + digit
  always_comb begin
    mac_sum = {1'b0, acc_i, 3'b000} + {3'b000, acc_i, 1'b0} + {28'd0, digit_i};
    mac_o   = (mac_sum > {4'd0, fld_o.max_val}) ? fld_o.max_val : mac_sum[AccW-1:0];
  end

  // Short fraction padded with zeros on close
  always_comb begin
    pad_idx  = fld_o.frac_digits - frac_cnt_i;
    pad_prod = acc_i * PadTab[pad_idx];
    if (frac_cnt_i == FracClosed || fld_o.frac_digits <= frac_cnt_i) begin
      close_o = acc_i;
    end else if (pad_prod > {{PadW{1'b0}}, fld_o.max_val}) begin
      close_o = fld_o.max_val;
    end else begin
      close_o = pad_prod[AccW-1:0];
    end
  end

endmodule

/* hdl/nmea_rmc_sentence_parser_core.sv */
// Top level of the RMC sentence parser: byte register, sentence state and result register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | into core | in_valid_i / in_stall_o  | rx_byte_i
//  out     | from core | out_valid_o / out_stall_i | utc_time_o .. date_code_o (one fix)
//
// A byte is taken in every cycle while the output is not held; it waits in
// the byte register, and its effect on the sentence state (and any fix it
// completes) is registered when that byte moves on, so a fix becomes valid
// once its closing carriage return has moved on from the byte register.
// The sentence state advances only when the result register can take a fix,
// so a stalled output holds the byte register and then stalls the input.
// Reset clears all parser state; the result payload has no reset.
module nmea_rmc_sentence_parser_core import nrmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [17:0] utc_time_o,
  output logic [26:0] latitude_o,
  output logic        lat_south_o,
  output logic [27:0] longitude_o,
  output logic        lon_west_o,
  output logic [23:0] speed_knots_o,
  output logic [15:0] heading_o,
  output logic [18:0] date_code_o
);

  // Byte register
  logic       byte_vld_q;
  logic [7:0] byte_q;
  logic       adv;
  logic       emit;

  // Sentence state
  logic            in_sent_q, in_sent_d;
  logic [2:0]      hdr_pos_q, hdr_pos_d;
  logic            hdr_ok_q, hdr_ok_d;
  logic [3:0]      fld_idx_q, fld_idx_d;
  logic [7:0]      char_cnt_q, char_cnt_d;
  logic            after_pt_q, after_pt_d;
  logic [2:0]      frac_cnt_q, frac_cnt_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic            fix_valid_q, fix_valid_d;
  logic [1:0]      ns_ok_q, ns_ok_d;
  logic [1:0]      ew_ok_q, ew_ok_d;
  logic [17:0]     held_time_q, held_time_d, held_time_st;
  logic [26:0]     held_lat_q, held_lat_d, held_lat_st;
  logic [27:0]     held_lon_q, held_lon_d, held_lon_st;
  logic [23:0]     held_speed_q, held_speed_d, held_speed_st;
  logic [15:0]     held_head_q, held_head_d, held_head_st;
  logic [18:0]     held_date_q, held_date_d, held_date_st;

  // Result register
  logic out_vld_q;

  nrmc_fld_t       fld;
  logic [AccW-1:0] mac_val;
  logic [AccW-1:0] close_val;
  logic [2:0]      hdr_idx;

  nrmc_num_unit u_num (
    .field_idx_i (fld_idx_q),
    .acc_i       (acc_q),
    .frac_cnt_i  (frac_cnt_q),
    .digit_i     (byte_q[3:0]),
    .fld_o       (fld),
    .mac_o       (mac_val),
    .close_o     (close_val)
  );

  // The pending byte moves on whenever the result slot is empty or draining.
  assign adv        = byte_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = byte_vld_q && !adv;
  assign hdr_idx    = hdr_pos_q - 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      byte_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= rx_byte_i;
    end
  end

  // Held values as they stand once the current field is closed and stored
  always_comb begin
    held_time_st  = held_time_q;
    held_lat_st   = held_lat_q;
    held_lon_st   = held_lon_q;
    held_speed_st = held_speed_q;
    held_head_st  = held_head_q;
    held_date_st  = held_date_q;
    case (fld_idx_q)
      FldTime:  held_time_st  = close_val[17:0];
      FldLat:   held_lat_st   = close_val[26:0];
      FldLon:   held_lon_st   = close_val[27:0];
      FldSpeed: held_speed_st = close_val[23:0];
      FldHead:  held_head_st  = close_val[15:0];
      FldDate:  held_date_st  = close_val[18:0];
      default:  ;
    endcase
  end

  // Next sentence state for the byte in the byte register
  always_comb begin
    in_sent_d    = in_sent_q;
    hdr_pos_d    = hdr_pos_q;
    hdr_ok_d     = hdr_ok_q;
    fld_idx_d    = fld_idx_q;
    char_cnt_d   = char_cnt_q;
    after_pt_d   = after_pt_q;
    frac_cnt_d   = frac_cnt_q;
    acc_d        = acc_q;
    fix_valid_d  = fix_valid_q;
    ns_ok_d      = ns_ok_q;
    ew_ok_d      = ew_ok_q;
    held_time_d  = held_time_q;
    held_lat_d   = held_lat_q;
    held_lon_d   = held_lon_q;
    held_speed_d = held_speed_q;
    held_head_d  = held_head_q;
    held_date_d  = held_date_q;
    emit         = 1'b0;

    if (byte_q == CharDollar) begin
      // Start (or restart) of a sentence wipes everything
      in_sent_d    = 1'b1;
      hdr_pos_d    = 3'd1;
      hdr_ok_d     = 1'b0;
      fld_idx_d    = 4'd0;
      char_cnt_d   = 8'd1;
      after_pt_d   = 1'b0;
      frac_cnt_d   = 3'd0;
      acc_d        = '0;
      fix_valid_d  = 1'b0;
      ns_ok_d      = 2'd0;
      ew_ok_d      = 2'd0;
      held_time_d  = '0;
      held_lat_d   = '0;
      held_lon_d   = '0;
      held_speed_d = '0;
      held_head_d  = '0;
      held_date_d  = '0;
    end else if (in_sent_q) begin
      if (byte_q == CharCr) begin
        if (hdr_ok_q) begin
          held_time_d  = held_time_st;
          held_lat_d   = held_lat_st;
          held_lon_d   = held_lon_st;
          held_speed_d = held_speed_st;
          held_head_d  = held_head_st;
          held_date_d  = held_date_st;
          emit         = fix_valid_q && ns_ok_q[0] && ew_ok_q[0];
        end
        in_sent_d = 1'b0;
      end else if (char_cnt_q >= 8'(MaxSentenceLen)) begin
        in_sent_d = 1'b0;   // overlong, drop
      end else begin
        char_cnt_d = char_cnt_q + 8'd1;
        if (!hdr_ok_q) begin
          if (hdr_pos_q inside {[3'd1:3'd5]} && byte_q == HdrText[hdr_idx]) begin
            hdr_pos_d = hdr_pos_q + 3'd1;
            if (hdr_pos_q == 3'd5) begin
              hdr_ok_d = 1'b1;
            end
          end else begin
            in_sent_d = 1'b0;
          end
        end else if (byte_q == CharComma) begin
          held_time_d  = held_time_st;
          held_lat_d   = held_lat_st;
          held_lon_d   = held_lon_st;
          held_speed_d = held_speed_st;
          held_head_d  = held_head_st;
          held_date_d  = held_date_st;
          if (fld_idx_q != FldLast) begin
            fld_idx_d = fld_idx_q + 4'd1;
          end
          acc_d      = '0;
          after_pt_d = 1'b0;
          frac_cnt_d = 3'd0;
        end else if (fld_idx_q == FldValid || fld_idx_q == FldNs || fld_idx_q == FldEw) begin
          // Letter fields: first byte only, accumulator marks it as seen
          if (acc_q == '0) begin
            acc_d = AccW'(1);
            if (fld_idx_q == FldValid) begin
              fix_valid_d = (byte_q == CharA);
            end else if (fld_idx_q == FldNs) begin
              ns_ok_d = (byte_q == CharN) ? 2'b01 : (byte_q == CharS) ? 2'b11 : 2'b00;
            end else begin
              ew_ok_d = (byte_q == CharE) ? 2'b01 : (byte_q == CharW) ? 2'b11 : 2'b00;
            end
          end
        end else if (fld.is_num && frac_cnt_q != FracClosed) begin
          if (byte_q inside {[Char0:Char9]}) begin
            if (!after_pt_q) begin
              acc_d = mac_val;
            end else if (frac_cnt_q < fld.frac_digits) begin
              acc_d      = mac_val;
              frac_cnt_d = frac_cnt_q + 3'd1;
            end
          end else if (byte_q == CharDot && !after_pt_q) begin
            after_pt_d = 1'b1;
          end else begin
            acc_d      = close_val;
            frac_cnt_d = FracClosed;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sent_q    <= 1'b0;
      hdr_pos_q    <= 3'd0;
      hdr_ok_q     <= 1'b0;
      fld_idx_q    <= 4'd0;
      char_cnt_q   <= 8'd0;
      after_pt_q   <= 1'b0;
      frac_cnt_q   <= 3'd0;
      acc_q        <= '0;
      fix_valid_q  <= 1'b0;
      ns_ok_q      <= 2'd0;
      ew_ok_q      <= 2'd0;
      held_time_q  <= '0;
      held_lat_q   <= '0;
      held_lon_q   <= '0;
      held_speed_q <= '0;
      held_head_q  <= '0;
      held_date_q  <= '0;
    end else if (adv) begin
      in_sent_q    <= in_sent_d;
      hdr_pos_q    <= hdr_pos_d;
      hdr_ok_q     <= hdr_ok_d;
      fld_idx_q    <= fld_idx_d;
      char_cnt_q   <= char_cnt_d;
      after_pt_q   <= after_pt_d;
      frac_cnt_q   <= frac_cnt_d;
      acc_q        <= acc_d;
      fix_valid_q  <= fix_valid_d;
      ns_ok_q      <= ns_ok_d;
      ew_ok_q      <= ew_ok_d;
      held_time_q  <= held_time_d;
      held_lat_q   <= held_lat_d;
      held_lon_q   <= held_lon_d;
      held_speed_q <= held_speed_d;
      held_head_q  <= held_head_d;
      held_date_q  <= held_date_d;
    end
  end

  // Result register: a fix request waits here until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= emit;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      utc_time_o    <= held_time_st;
      latitude_o    <= held_lat_st;
      lat_south_o   <= ns_ok_q[1];
      longitude_o   <= held_lon_st;
      lon_west_o    <= ew_ok_q[1];
      speed_knots_o <= held_speed_st;
      heading_o     <= held_head_st;
      date_code_o   <= held_date_st;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule
